### sv/rig_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rig_pkg;

    localparam int INDEX_BITS  = 31;
    localparam int BASE_BITS   = 8;
    localparam int FRAC_BITS   = 32;

    // Quotient bits resolved per cycle while a digit is split off the index.
    localparam int DIGIT_STEPS = 4;
    localparam int DIV_CYC     = (INDEX_BITS + DIGIT_STEPS - 1) / DIGIT_STEPS;
    localparam int WORK_BITS   = DIV_CYC * DIGIT_STEPS;

    // The denominator is base to the power of the digit count, at most index times base.
    localparam int DEN_W       = INDEX_BITS + BASE_BITS;
    localparam int CNT_W       = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_FRAC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### sv/rig_digit_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rig_digit_step (
    input  wire logic [rig_pkg::WORK_BITS-1:0] i_work,
    input  wire logic [rig_pkg::BASE_BITS-1:0] i_rem,
    input  wire logic [rig_pkg::BASE_BITS-1:0] i_base,
    output logic      [rig_pkg::WORK_BITS-1:0] o_work,
    output logic      [rig_pkg::BASE_BITS-1:0] o_rem
);
    import rig_pkg::*;

    logic [WORK_BITS-1:0] w;
    logic [BASE_BITS-1:0] r;
    logic [BASE_BITS:0]   t;

    // Restoring division, most significant bit first. The dividend shifts out at
    // the top of the word while the quotient bits shift in at the bottom.
    always_comb begin
        w = i_work;
        r = i_rem;
        t = '0;
        for (int s = 0; s < DIGIT_STEPS; s++) begin
            t = {r, w[WORK_BITS-1]};
            w = {w[WORK_BITS-2:0], 1'b0};
            if (t >= {1'b0, i_base}) begin
                t    = t - {1'b0, i_base};
                w[0] = 1'b1;
            end
            r = t[BASE_BITS-1:0];
        end
        o_work = w;
        o_rem  = r;
    end

endmodule

`default_nettype wire

### sv/rig_frac_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rig_frac_step (
    input  wire logic [rig_pkg::DEN_W-1:0] i_rem,
    input  wire logic [rig_pkg::DEN_W-1:0] i_den,
    output logic      [rig_pkg::DEN_W-1:0] o_rem,
    output logic                           o_bit
);
    import rig_pkg::*;

    logic [DEN_W:0] t;
    logic [DEN_W:0] d;

    // One binary long-division step; the remainder stays below the denominator.
    always_comb begin
        t     = {i_rem, 1'b0};
        d     = t - {1'b0, i_den};
        o_bit = (t >= {1'b0, i_den});
        o_rem = o_bit ? d[DEN_W-1:0] : t[DEN_W-1:0];
    end

endmodule

`default_nettype wire

### sv/radical_inverse_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Halton radical inverse of an index in a run-time base.
// Input channel: i_valid / o_ready carry i_index and i_base. Output channel:
// o_valid / i_ready carry o_fraction, floor(2^32 times the mirrored digit
// string read as a fraction), an unsigned Q0.32 value.
// One item is in flight at a time: o_ready is high only while the block is
// idle. Each base-b digit is split off the index in ST_DIV by a divider that
// resolves four quotient bits a cycle; ST_ACC then folds it into the numerator
// and denominator. A final binary long division in ST_FRAC turns numerator over
// denominator into the fraction. An index of zero, or a base below two, gives a
// fraction of zero in the cycle after the transfer. The next item is taken in
// the cycle after the output transfer.
// The result is held in its register with o_valid high until the receiver
// takes it; a stalled receiver simply delays the return to idle.
// Reset (synchronous, active low) returns the block to idle and drops o_valid.
module radical_inverse_generator_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rig_pkg::INDEX_BITS-1:0] i_index,
    input  wire logic [rig_pkg::BASE_BITS-1:0]  i_base,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [rig_pkg::FRAC_BITS-1:0]  o_fraction
);
    import rig_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORK_BITS-1:0] r_work, n_work;
    logic [BASE_BITS-1:0] r_base, n_base;
    logic [BASE_BITS-1:0] r_rem, n_rem;
    logic [DEN_W-1:0]     r_num, n_num;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [FRAC_BITS-1:0] r_frac, n_frac;

    logic [WORK_BITS-1:0]       dig_work;
    logic [BASE_BITS-1:0]       dig_rem;
    logic [DEN_W-1:0]           fr_rem;
    logic                       fr_bit;
    logic [DEN_W+BASE_BITS-1:0] num_prod;
    logic [DEN_W+BASE_BITS-1:0] den_prod;

    rig_digit_step u_digit (
        .i_work (r_work),
        .i_rem  (r_rem),
        .i_base (r_base),
        .o_work (dig_work),
        .o_rem  (dig_rem)
    );

    rig_frac_step u_frac (
        .i_rem  (r_num),
        .i_den  (r_den),
        .o_rem  (fr_rem),
        .o_bit  (fr_bit)
    );

    assign num_prod = r_num * r_base;
    assign den_prod = r_den * r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_base <= n_base;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_den  <= n_den;
        r_frac <= n_frac;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_work  = r_work;
        n_base  = r_base;
        n_rem   = r_rem;
        n_num   = r_num;
        n_den   = r_den;
        n_frac  = r_frac;
        o_ready = 1'b0;
        o_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_work = WORK_BITS'(i_index);
                    n_base = i_base;
                    n_rem  = '0;
                    n_num  = '0;
                    n_den  = DEN_W'(1);
                    n_frac = '0;
                    n_cnt  = '0;
                    if (i_index == '0 || i_base < BASE_BITS'(2)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_work = dig_work;
                n_rem  = dig_rem;
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                // The digit just split off goes in as the next less significant one.
                n_num = num_prod[DEN_W-1:0] + DEN_W'(r_rem);
                n_den = den_prod[DEN_W-1:0];
                n_rem = '0;
                n_cnt = '0;
                if (r_work == '0) begin
                    n_state = ST_FRAC;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_FRAC: begin
                n_num  = fr_rem;
                n_frac = {r_frac[FRAC_BITS-2:0], fr_bit};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_fraction = r_frac;

endmodule

`default_nettype wire

### sv/rig_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rig_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire logic [rig_pkg::INDEX_BITS-1:0] i_index,
    input wire logic [rig_pkg::BASE_BITS-1:0]  i_base,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [rig_pkg::FRAC_BITS-1:0]  o_fraction
);

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fraction))
        else $error("result changed or withdrawn before its transfer");

    // Only one item is in flight: no new input while a result is offered.
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result is pending");

    // After an input transfer the block is busy.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready directly after an input transfer");

    // Once the result is taken the block is ready again.
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready && !o_valid)
        else $error("block not idle after the output transfer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

endmodule

bind radical_inverse_generator_core rig_checker u_rig_checker (.*);

`default_nettype wire
